### design/sqlc_pkg.sv
package sqlc_pkg;

  localparam int unsigned DefMaxTag   = 32;
  localparam int unsigned DefMaxDepth = 255;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChLowE   = 8'h65;

  typedef enum logic [3:0] {
    MODE_NORMAL   = 4'd0,
    MODE_DASH     = 4'd1,
    MODE_SLASH    = 4'd2,
    MODE_LINE     = 4'd3,
    MODE_BLOCK    = 4'd4,
    MODE_BLOCK_SL = 4'd5,
    MODE_BLOCK_ST = 4'd6,
    MODE_QUOTED   = 4'd7,
    MODE_QCLOSE   = 4'd8,
    MODE_TAG      = 4'd9,
    MODE_BODY     = 4'd10,
    MODE_DONE     = 4'd11
  } scan_mode_e;

  typedef struct packed {
    scan_mode_e mode;
    logic       qdbl;
    logic       first_seen;
    logic       after_semi;
    logic       multiple;
    logic [2:0] expl_prog;
    logic       expl_seen;
    logic       overflow;
  } scan_state_t;

  // Controls for the tag cell row
  typedef struct packed {
    logic load;   // restart the write token at the head
    logic shift;  // store the word and advance the write token
    logic scan;   // advance the match token
    logic clear;  // drop the match token
  } chain_ctrl_t;

  typedef struct packed {
    logic single_statement;
    logic starts_with_explain;
    logic limit_exceeded;
  } result_t;

  localparam scan_state_t ScanReset = '{
    mode: MODE_NORMAL, qdbl: 1'b0, first_seen: 1'b0, after_semi: 1'b0,
    multiple: 1'b0, expl_prog: 3'd0, expl_seen: 1'b0, overflow: 1'b0
  };

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] explain_char(logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h65;
      3'd1:    r = 8'h78;
      3'd2:    r = 8'h70;
      3'd3:    r = 8'h6C;
      3'd4:    r = 8'h61;
      3'd5:    r = 8'h69;
      3'd6:    r = 8'h6E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic scan_state_t sig_byte(scan_state_t s, logic [7:0] c);
    scan_state_t r;
    r = s;
    if (s.after_semi) begin
      r.multiple = 1'b1;
      r.mode     = MODE_DONE;
    end else begin
      if (!s.first_seen) begin
        r.first_seen = 1'b1;
        if (to_lower(c) == ChLowE) r.expl_prog = 3'd1;
      end
      if (c == ChSquote || c == ChDquote) begin
        r.qdbl = (c == ChDquote);
        r.mode = MODE_QUOTED;
      end else if (c == ChDollar) begin
        r.mode = MODE_TAG;
      end else begin
        r.after_semi = (c == ChSemi);
      end
    end
    return r;
  endfunction

  function automatic scan_state_t normal_byte(scan_state_t s, logic [7:0] c);
    scan_state_t r;
    r = s;
    r.mode = MODE_NORMAL;
    if (is_space(c)) begin
      return r;
    end
    if (c == ChDash) begin
      r.mode = MODE_DASH;
    end else if (c == ChSlash) begin
      r.mode = MODE_SLASH;
    end else begin
      r = sig_byte(r, c);
    end
    return r;
  endfunction

endpackage

### design/sqlc_cell.sv
module sqlc_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           char_i,
  input  sqlc_pkg::chain_ctrl_t ctrl_i,
  input  logic                 first_i,
  input  logic                 wtok_i,
  input  logic                 tok_i,
  output logic                 wtok_o,
  output logic                 tok_o,
  output logic                 close_o
);
  import sqlc_pkg::*;

  logic [7:0] tag_q, tag_d;
  logic       wtok_q, wtok_d;
  logic       tok_q, tok_d;

  // The write token marks the cell that takes the next tag word; once the
  // tag is complete it rests on the cell that expects the closing '$'.
  always_comb begin
    tag_d  = tag_q;
    wtok_d = wtok_q;
    tok_d  = tok_q;
    if (ctrl_i.load) begin
      wtok_d = first_i;
    end else if (ctrl_i.shift) begin
      wtok_d = wtok_i;
      if (wtok_q) tag_d = char_i;
    end
    if (ctrl_i.clear) begin
      tok_d = 1'b0;
    end else if (ctrl_i.scan) begin
      tok_d = tok_i;
    end
  end

  assign wtok_o  = wtok_q;
  assign tok_o   = tok_q && !wtok_q && (char_i == tag_q);
  assign close_o = tok_q && wtok_q && (char_i == ChDollar);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wtok_q <= 1'b0;
      tok_q  <= 1'b0;
    end else begin
      wtok_q <= wtok_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

endmodule

### design/sqlc_scan_ctrl.sv
module sqlc_scan_ctrl #(
  parameter int unsigned MaxTag   = sqlc_pkg::DefMaxTag,
  parameter int unsigned MaxDepth = sqlc_pkg::DefMaxDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            char_i,
  input  logic                  last_i,
  input  logic                  close_i,
  output sqlc_pkg::chain_ctrl_t ctrl_o,
  output logic                  res_fire_o,
  output sqlc_pkg::result_t     res_o
);
  import sqlc_pkg::*;

  localparam int unsigned TagLenW = $clog2(MaxTag + 1);
  localparam int unsigned DepthW  = $clog2(MaxDepth + 1);

  scan_state_t       st_q, st_d, st_n;
  logic [TagLenW-1:0] tlen_q, tlen_d;
  logic [DepthW-1:0]  depth_q, depth_d;
  logic [7:0]         quote_ch;
  logic               tag_room;

  assign quote_ch = st_q.qdbl ? ChDquote : ChSquote;
  assign tag_room = tlen_q < TagLenW'(MaxTag);

  // Next state for one word
  always_comb begin
    st_n    = st_q;
    depth_d = depth_q;
    tlen_d  = tlen_q;

    if (st_q.expl_prog != 3'd0 && st_q.expl_prog != 3'd7) begin
      if (to_lower(char_i) == explain_char(st_q.expl_prog)) begin
        st_n.expl_prog = st_q.expl_prog + 3'd1;
        if (st_q.expl_prog == 3'd6) st_n.expl_seen = 1'b1;
      end else begin
        st_n.expl_prog = 3'd0;
      end
    end

    unique case (st_q.mode)
      MODE_NORMAL: st_n = normal_byte(st_n, char_i);
      MODE_DASH: begin
        if (char_i == ChDash) begin
          st_n.mode = MODE_LINE;
        end else begin
          st_n.mode = MODE_NORMAL;
          st_n = sig_byte(st_n, ChDash);
          if (st_n.mode == MODE_NORMAL) st_n = normal_byte(st_n, char_i);
        end
      end
      MODE_SLASH: begin
        if (char_i == ChStar) begin
          depth_d   = DepthW'(1);
          st_n.mode = MODE_BLOCK;
        end else begin
          st_n.mode = MODE_NORMAL;
          st_n = sig_byte(st_n, ChSlash);
          if (st_n.mode == MODE_NORMAL) st_n = normal_byte(st_n, char_i);
        end
      end
      MODE_LINE: begin
        if (char_i == ChLf) st_n.mode = MODE_NORMAL;
      end
      MODE_BLOCK, MODE_BLOCK_SL, MODE_BLOCK_ST: begin
        if (st_q.mode == MODE_BLOCK_SL && char_i == ChStar) begin
          if (depth_q >= DepthW'(MaxDepth)) begin
            st_n.overflow = 1'b1;
          end else begin
            depth_d = depth_q + DepthW'(1);
          end
          st_n.mode = MODE_BLOCK;
        end else if (st_q.mode == MODE_BLOCK_ST && char_i == ChSlash) begin
          depth_d   = depth_q - DepthW'(1);
          st_n.mode = (depth_q == DepthW'(1)) ? MODE_NORMAL : MODE_BLOCK;
        end else if (char_i == ChSlash) begin
          st_n.mode = MODE_BLOCK_SL;
        end else if (char_i == ChStar) begin
          st_n.mode = MODE_BLOCK_ST;
        end else begin
          st_n.mode = MODE_BLOCK;
        end
      end
      MODE_QUOTED: begin
        if (char_i == quote_ch) st_n.mode = MODE_QCLOSE;
      end
      MODE_QCLOSE: begin
        if (char_i == quote_ch) begin
          st_n.mode = MODE_QUOTED;
        end else begin
          st_n = normal_byte(st_n, char_i);
        end
      end
      MODE_TAG: begin
        if (char_i == ChDollar) begin
          st_n.mode = MODE_BODY;
        end else if (is_word(char_i) && tag_room) begin
          tlen_d = tlen_q + TagLenW'(1);
        end else begin
          if (is_word(char_i)) st_n.overflow = 1'b1;
          st_n = normal_byte(st_n, char_i);
        end
      end
      MODE_BODY: begin
        if (close_i) st_n.mode = MODE_NORMAL;
      end
      MODE_DONE: ;
      default: ;
    endcase

    if (st_n.mode == MODE_TAG && st_q.mode != MODE_TAG) tlen_d = '0;

    // A trailing lone dash or slash still counts as text
    st_d = st_n;
    if (st_n.mode == MODE_DASH) begin
      st_d.mode = MODE_NORMAL;
      st_d = sig_byte(st_d, ChDash);
    end else if (st_n.mode == MODE_SLASH) begin
      st_d.mode = MODE_NORMAL;
      st_d = sig_byte(st_d, ChSlash);
    end
  end

  // Outputs toward the cell row and the result register
  always_comb begin
    ctrl_o.load  = accept_i && st_n.mode == MODE_TAG && st_q.mode != MODE_TAG;
    ctrl_o.shift = accept_i && st_q.mode == MODE_TAG && is_word(char_i) && tag_room;
    ctrl_o.scan  = accept_i && st_q.mode == MODE_BODY;
    ctrl_o.clear = accept_i && st_q.mode == MODE_TAG && char_i == ChDollar;
    res_fire_o   = accept_i && last_i;
    res_o.single_statement    = !st_d.multiple;
    res_o.starts_with_explain = st_d.expl_seen;
    res_o.limit_exceeded      = st_d.overflow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ScanReset;
      tlen_q  <= '0;
      depth_q <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        st_q    <= ScanReset;
        tlen_q  <= '0;
        depth_q <= '0;
      end else begin
        st_q    <= st_n;
        tlen_q  <= tlen_d;
        depth_q <= depth_d;
      end
    end
  end

  a_depth_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.mode == MODE_BLOCK || st_q.mode == MODE_BLOCK_SL ||
     st_q.mode == MODE_BLOCK_ST) |-> depth_q != '0)
    else $error("comment nesting count is zero inside a comment");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(MaxDepth))
    else $error("comment nesting count above its bound");

  a_tag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tlen_q <= TagLenW'(MaxTag))
    else $error("tag length above its bound");

endmodule

### design/sql_statement_classifier_core.sv
// Byte-serial SQL statement classifier. One text byte is taken per clock
// and a new byte may follow every cycle; the result for a text appears in
// the output register in the cycle after its last byte and waits there while
// the next text streams in. The throughput of one byte per cycle is set by
// the scan controller together with a row of MaxTag+1 tag
// cells: each cell holds one byte of the current dollar-quote tag, and a
// one-hot match token steps from cell to cell as the closing tag arrives,
// so no stored tag byte is ever looked up by address. No clearing pass is
// needed after reset. The input stalls only while the last byte of a text
// waits for the previous result, still held back by the output side.
module sql_statement_classifier_core #(
  parameter int unsigned MaxTag   = sqlc_pkg::DefMaxTag,
  parameter int unsigned MaxDepth = sqlc_pkg::DefMaxDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       single_statement_o,
  output logic       starts_with_explain_o,
  output logic       limit_exceeded_o
);
  import sqlc_pkg::*;

  localparam int unsigned NumCells = MaxTag + 1;

  logic                accept;
  chain_ctrl_t         ctrl;
  logic                res_fire;
  result_t             res;
  result_t             res_q;
  logic                out_valid_q, out_valid_d;
  logic [NumCells-1:0] wtok;
  logic [NumCells-1:0] tok;
  logic [NumCells-1:0] close_vec;
  logic [NumCells-1:0] wtok_left;
  logic [NumCells-1:0] tok_left;

  // Hold only a last word whose result has nowhere to go
  assign in_stall_o = out_valid_q && out_stall_i && last_i;
  assign accept     = in_valid_i && !in_stall_o;

  sqlc_scan_ctrl #(
    .MaxTag  (MaxTag),
    .MaxDepth(MaxDepth)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .char_i    (char_in_i),
    .last_i    (last_i),
    .close_i   (|close_vec),
    .ctrl_o    (ctrl),
    .res_fire_o(res_fire),
    .res_o     (res)
  );

  // A '$' in the body always restarts the match at the head cell
  assign wtok_left[0] = 1'b0;
  assign tok_left[0]  = (char_in_i == ChDollar);

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign wtok_left[i] = wtok[i-1];
      assign tok_left[i]  = tok[i-1];
    end
    sqlc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .char_i (char_in_i),
      .ctrl_i (ctrl),
      .first_i(i == 0),
      .wtok_i (wtok_left[i]),
      .tok_i  (tok_left[i]),
      .wtok_o (wtok[i]),
      .tok_o  (tok[i]),
      .close_o(close_vec[i])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) res_q <= res;
  end

  assign out_valid_o           = out_valid_q;
  assign single_statement_o    = res_q.single_statement;
  assign starts_with_explain_o = res_q.starts_with_explain;
  assign limit_exceeded_o      = res_q.limit_exceeded;

  a_wtok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wtok))
    else $error("more than one tag write position");

  a_close_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(close_vec))
    else $error("closing tag matched in more than one cell");

  a_fire_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |-> !(out_valid_q && out_stall_i))
    else $error("result produced while output register is held");

endmodule
